// ===== sv/rrmq_pkg.sv =====
// shared constants, codes and helpers for the reclaiming ring message queue
package rrmq_pkg;

    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int FUNC_W      = 2;
    localparam int MSG_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int SIZE_W      = 7;
    localparam int SLOT_W      = (HANDLE_BITS < MSG_W) ? HANDLE_BITS : MSG_W;
    localparam int CMP_W       = (PTR_W + 1 > SIZE_W) ? PTR_W + 1 : SIZE_W;
    localparam int SIZE_RESET  = (DEPTH < 64) ? DEPTH : 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_ACQUIRE = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_FULL          = 3'd1,
        ST_NOTHING_STALE = 3'd2,
        ST_EMPTY         = 3'd3,
        ST_MISUSE        = 3'd4
    } status_t;

    // next ring position, wrapping at the configured size
    function automatic logic [PTR_W-1:0] ptr_advance(
        input logic [PTR_W-1:0]  p,
        input logic [SIZE_W-1:0] size
    );
        logic [CMP_W-1:0] n;
        n = CMP_W'(p) + CMP_W'(1);
        return (n >= CMP_W'(size)) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

// ===== sv/rrmq_if.sv =====
// valid/ready channel interfaces for the queue request and result streams
interface rrmq_in_if;
    logic                        valid;
    logic                        ready;
    logic [rrmq_pkg::FUNC_W-1:0] func;
    logic [rrmq_pkg::MSG_W-1:0]  msg;

    modport source (output valid, func, msg, input ready);
    modport sink   (input valid, func, msg, output ready);
endinterface

interface rrmq_out_if;
    logic                          valid;
    logic                          ready;
    logic [rrmq_pkg::STATUS_W-1:0] status;
    logic [rrmq_pkg::MSG_W-1:0]    msg_out;

    modport source (output valid, status, msg_out, input ready);
    modport sink   (input valid, status, msg_out, output ready);
endinterface

// ===== sv/reclaiming_ring_message_queue_top.sv =====
// reclaiming ring message queue: slot memory with write, read and free pointers
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        func, msg
//   out_ch    out   valid/ready        status, msg_out
//   cfg       in    cfg_wr_en          cfg_wr_data (queue size in use)
//
// each request takes a registered slot memory read, then decide and write back
// one request in flight; in_ch.ready is high whenever the sequencer is idle,
// so the next request is taken while a result still waits on out_ch
// a stalled out_ch holds the sequencer in the decide step until the result
// register frees up
// reset and a size write empty all slots at once (per-slot valid flops),
// zero the pointers and drop the held handle; no clearing pass
module reclaiming_ring_message_queue_top (
    input  logic                          clk,
    input  logic                          rst_n,
    rrmq_in_if.sink                       in_ch,
    rrmq_out_if.source                    out_ch,
    input  logic                          cfg_wr_en,
    input  logic [rrmq_pkg::SIZE_W-1:0]   cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECIDE = 2'b10
    } fsm_t;

    fsm_t                              state_reg, state_next;
    rrmq_pkg::func_t                   func_reg;
    logic [rrmq_pkg::SLOT_W-1:0]       msg_reg;
    logic [rrmq_pkg::PTR_W-1:0]        addr_reg;
    logic [rrmq_pkg::SIZE_W-1:0]       size_reg, size_next;
    logic [rrmq_pkg::PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg, fr_ptr_reg;
    logic [rrmq_pkg::SLOT_W-1:0]       held_reg;
    logic [rrmq_pkg::DEPTH-1:0]        valid_reg;
    logic                              slot_valid_reg;
    logic [rrmq_pkg::SLOT_W-1:0]       rd_data_reg;
    logic                              out_valid_reg;
    rrmq_pkg::status_t                 out_status_reg;
    logic [rrmq_pkg::MSG_W-1:0]        out_msg_reg;

    // slot storage, one write and one read port
    logic [rrmq_pkg::SLOT_W-1:0]       slot_mem [rrmq_pkg::DEPTH];

    logic                              in_fire;
    logic                              decide_fire;
    logic [rrmq_pkg::PTR_W-1:0]        rd_addr;
    logic [rrmq_pkg::SLOT_W-1:0]       slot_val;

    // decide step results
    rrmq_pkg::status_t                 status_d;
    logic [rrmq_pkg::SLOT_W-1:0]       res_d;
    logic                              mem_we;
    logic                              valid_clr;
    logic                              wr_adv, rd_adv, fr_adv;
    logic                              held_load, held_clr;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign decide_fire    = (state_reg == S_DECIDE) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.status  = out_status_reg;
    assign out_ch.msg_out = out_msg_reg;

    // pick the slot each operation looks at
    always_comb
    begin
        case (rrmq_pkg::func_t'(in_ch.func))
            rrmq_pkg::FUNC_ADD:     rd_addr = wr_ptr_reg;
            rrmq_pkg::FUNC_REMOVE:  rd_addr = fr_ptr_reg;
            rrmq_pkg::FUNC_ACQUIRE: rd_addr = rd_ptr_reg;
            default:                rd_addr = rd_ptr_reg;
        endcase
    end

    // an invalid slot reads as empty
    assign slot_val = slot_valid_reg ? rd_data_reg : '0;

    // decide: status, returned handle and state updates
    always_comb
    begin
        status_d  = rrmq_pkg::ST_OK;
        res_d     = '0;
        mem_we    = 1'b0;
        valid_clr = 1'b0;
        wr_adv    = 1'b0;
        rd_adv    = 1'b0;
        fr_adv    = 1'b0;
        held_load = 1'b0;
        held_clr  = 1'b0;
        case (func_reg)
            rrmq_pkg::FUNC_ADD:
            begin
                if (msg_reg == '0)
                    status_d = rrmq_pkg::ST_MISUSE;
                else if (slot_valid_reg)
                    status_d = rrmq_pkg::ST_FULL;
                else
                begin
                    mem_we = 1'b1;
                    wr_adv = 1'b1;
                end
            end
            rrmq_pkg::FUNC_REMOVE:
            begin
                if (fr_ptr_reg == rd_ptr_reg)
                    status_d = rrmq_pkg::ST_NOTHING_STALE;
                else if (!slot_valid_reg)
                    status_d = rrmq_pkg::ST_MISUSE;
                else
                begin
                    res_d     = slot_val;
                    valid_clr = 1'b1;
                    fr_adv    = 1'b1;
                end
            end
            rrmq_pkg::FUNC_ACQUIRE:
            begin
                if (held_reg != '0)
                    status_d = rrmq_pkg::ST_MISUSE;
                else if (rd_ptr_reg == wr_ptr_reg)
                    status_d = rrmq_pkg::ST_EMPTY;
                else
                begin
                    res_d     = slot_val;
                    held_load = 1'b1;
                end
            end
            rrmq_pkg::FUNC_RELEASE:
            begin
                if (msg_reg == '0 || msg_reg != held_reg)
                    status_d = rrmq_pkg::ST_MISUSE;
                else
                begin
                    held_clr = 1'b1;
                    rd_adv   = 1'b1;
                end
            end
            default:
            begin
                status_d = rrmq_pkg::ST_MISUSE;
            end
        endcase
    end

    // size write: zero counts as one, clamp to the ring depth
    always_comb
    begin
        size_next = cfg_wr_data;
        if (size_next == '0)
            size_next = rrmq_pkg::SIZE_W'(1);
        if (rrmq_pkg::CMP_W'(size_next) > rrmq_pkg::CMP_W'(rrmq_pkg::DEPTH))
            size_next = rrmq_pkg::SIZE_W'(rrmq_pkg::DEPTH);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_DECIDE;
            S_DECIDE: if (decide_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= rrmq_pkg::SIZE_W'(rrmq_pkg::SIZE_RESET);
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fr_ptr_reg    <= '0;
            held_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                // size write restarts the ring
                size_reg   <= size_next;
                wr_ptr_reg <= '0;
                rd_ptr_reg <= '0;
                fr_ptr_reg <= '0;
                held_reg   <= '0;
                valid_reg  <= '0;
            end
            else if (decide_fire)
            begin
                if (wr_adv)
                    wr_ptr_reg <= rrmq_pkg::ptr_advance(wr_ptr_reg, size_reg);
                if (rd_adv)
                    rd_ptr_reg <= rrmq_pkg::ptr_advance(rd_ptr_reg, size_reg);
                if (fr_adv)
                    fr_ptr_reg <= rrmq_pkg::ptr_advance(fr_ptr_reg, size_reg);
                if (held_load)
                    held_reg <= slot_val;
                else if (held_clr)
                    held_reg <= '0;
                if (mem_we)
                    valid_reg[addr_reg] <= 1'b1;
                else if (valid_clr)
                    valid_reg[addr_reg] <= 1'b0;
            end
            if (decide_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg       <= rrmq_pkg::func_t'(in_ch.func);
            msg_reg        <= in_ch.msg[rrmq_pkg::SLOT_W-1:0];
            addr_reg       <= rd_addr;
            slot_valid_reg <= valid_reg[rd_addr];
        end
        if (decide_fire)
        begin
            out_status_reg <= status_d;
            out_msg_reg    <= rrmq_pkg::MSG_W'(res_d);
        end
    end

    // slot memory: write back on decide, registered read on transfer in
    always_ff @(posedge clk)
    begin
        if (decide_fire && mem_we)
            slot_mem[addr_reg] <= msg_reg;
        if (in_fire)
            rd_data_reg <= slot_mem[rd_addr];
    end

endmodule

// ===== sv/rrmq_checker.sv =====
// port-level checks for the queue, bound to the top level
module rrmq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rrmq_pkg::STATUS_W-1:0] out_status,
    input logic [rrmq_pkg::MSG_W-1:0]    out_msg
);

    // one request in flight: ready drops right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after a request transfer");

    // a result waits for the slot memory read first
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after a request");

    // failed operations return no handle
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != rrmq_pkg::ST_OK) |-> (out_msg == '0))
        else $error("handle returned with a failing status");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_msg))
        else $error("stalled result changed");

endmodule

bind reclaiming_ring_message_queue_top rrmq_checker u_rrmq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_msg    (out_ch.msg_out)
);

// ===== bench/ring_queue_checker.sv =====
// reply checker for the reclaiming ring message queue: predicts every reply and compares
module ring_queue_checker
    import rrmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rrmq_in_if                req_ch,
    rrmq_out_if               rsp_ch,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                replies_owed
);

    typedef struct packed {
        status_t          status;
        logic [MSG_W-1:0] msg_out;
    } reply_t;

    logic [SLOT_W-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  fr_ptr;
    logic [SLOT_W-1:0] held;
    int unsigned       ring_len;
    reply_t            expected_replies [$];
    reply_t            want;
    int                shown;
    int unsigned       new_len;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        int unsigned n;
        n = p + 1;
        return (n >= ring_len) ? '0 : PTR_W'(n);
    endfunction

    function automatic void empty_ring();
        for (int i = 0; i < DEPTH; i++)
            slot_mem[i] = '0;
        wr_ptr = '0;
        rd_ptr = '0;
        fr_ptr = '0;
        held   = '0;
    endfunction

    // applies one request to the ring and returns the reply it should produce
    function automatic reply_t predict_ring_op(input func_t op, input logic [MSG_W-1:0] msg);
        reply_t            r;
        logic [SLOT_W-1:0] h;
        h = msg[SLOT_W-1:0];
        r.status  = ST_OK;
        r.msg_out = '0;
        case (op)
            FUNC_ADD:
            begin
                if (h == '0)
                    r.status = ST_MISUSE;
                else if (slot_mem[wr_ptr] != '0)
                    r.status = ST_FULL;
                else
                begin
                    slot_mem[wr_ptr] = h;
                    wr_ptr = step_ptr(wr_ptr);
                end
            end
            FUNC_REMOVE:
            begin
                if (fr_ptr == rd_ptr)
                    r.status = ST_NOTHING_STALE;
                else if (slot_mem[fr_ptr] == '0)
                    r.status = ST_MISUSE;
                else
                begin
                    r.msg_out = MSG_W'(slot_mem[fr_ptr]);
                    slot_mem[fr_ptr] = '0;
                    fr_ptr = step_ptr(fr_ptr);
                end
            end
            FUNC_ACQUIRE:
            begin
                if (held != '0)
                    r.status = ST_MISUSE;
                else if (rd_ptr == wr_ptr)
                    r.status = ST_EMPTY;
                else
                begin
                    held = slot_mem[rd_ptr];
                    r.msg_out = MSG_W'(held);
                end
            end
            default:
            begin
                if (h == '0 || h != held)
                    r.status = ST_MISUSE;
                else
                begin
                    held = '0;
                    rd_ptr = step_ptr(rd_ptr);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len = SIZE_RESET;
            empty_ring();
            expected_replies.delete();
            fail_count = 0;
            shown = 0;
            replies_owed <= 0;
        end
        else
        begin
            // a reply always belongs to an earlier request, so retire before predicting
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("unexpected reply: status %0d msg_out %h",
                                 rsp_ch.status, rsp_ch.msg_out);
                    end
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.msg_out !== want.msg_out)
                    begin
                        fail_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("reply mismatch: status exp %0d got %0d, msg_out exp %h got %h",
                                     want.status, rsp_ch.status, want.msg_out, rsp_ch.msg_out);
                        end
                    end
                end
            end
            if (cfg_wr_en)
            begin
                new_len = cfg_wr_data;
                if (new_len == 0)
                    new_len = 1;
                if (new_len > DEPTH)
                    new_len = DEPTH;
                ring_len = new_len;
                empty_ring();
            end
            if (req_ch.valid && req_ch.ready)
                expected_replies.push_back(predict_ring_op(func_t'(req_ch.func), req_ch.msg));
            replies_owed <= expected_replies.size();
        end
    end

endmodule

// ===== bench/reclaiming_ring_message_queue_top_test.sv =====
// stimulus and verdict for the reclaiming ring message queue
module reclaiming_ring_message_queue_top_test;
    import rrmq_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    int                fail_count;
    int                replies_owed;

    // request pacing and the one long reply hold-off
    int                requests_sent;
    int                send_idle_pct;
    bit                backlog_done;

    // stimulus-side view of the ring, in counts and queued handles; it steers requests toward
    // legal add / acquire / release / remove sequences
    int unsigned       ring_n;
    int unsigned       queued_cnt;
    int unsigned       stale_cnt;
    bit                holding;
    logic [MSG_W-1:0]  queued_handles [$];

    // size settings walked through by the random part, extremes included
    logic [SIZE_W-1:0] size_plan [13] = '{7'd3, 7'd64, 7'd1, 7'd2, 7'd127, 7'd5, 7'd0,
                                          7'd4, 7'd65, 7'd2, 7'd8, 7'd3, 7'd6};

    rrmq_in_if  req_ch ();
    rrmq_out_if rsp_ch ();

    reclaiming_ring_message_queue_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (req_ch),
        .out_ch      (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ring_queue_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_ch       (req_ch),
        .rsp_ch       (rsp_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("[reclaiming_ring_message_queue_top] ERROR");
        $finish;
    end

    // idle length: mostly from the short range, now and then from the long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [MSG_W-1:0] fresh_handle();
        logic [MSG_W-1:0] h;
        h = $urandom();
        if (h == '0)
            h = 1;
        return h;
    endfunction

    // keeps the count view in step with what the ring does with a request;
    // the free, read and write pointers meet when a count is zero or the whole ring
    function automatic void track_request(input func_t op, input logic [MSG_W-1:0] handle);
        case (op)
            FUNC_ADD:
            begin
                if (handle != '0 && queued_cnt + stale_cnt < ring_n)
                begin
                    queued_cnt++;
                    queued_handles.push_back(handle);
                end
            end
            FUNC_REMOVE:
            begin
                if (stale_cnt != 0 && stale_cnt != ring_n)
                    stale_cnt--;
            end
            FUNC_ACQUIRE:
            begin
                if (!holding && queued_cnt != 0 && queued_cnt != ring_n)
                    holding = 1'b1;
            end
            default:
            begin
                // the held handle is always the oldest one queued
                if (holding && handle != '0 && handle == queued_handles[0])
                begin
                    holding = 1'b0;
                    queued_cnt--;
                    stale_cnt++;
                    void'(queued_handles.pop_front());
                end
            end
        endcase
    endfunction

    // offers one request, holds it until the transfer, then maybe idles
    task automatic send_request(input func_t op, input logic [MSG_W-1:0] handle);
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.msg   <= handle;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        track_request(op, handle);
        requests_sent++;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // drops valid and waits until every predicted reply has been transferred
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
    endtask

    // size write while the block is idle; it also empties the ring
    task automatic write_ring_size(input logic [SIZE_W-1:0] value);
        wait_all_results();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ring_n = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : value;
        queued_cnt = 0;
        stale_cnt  = 0;
        holding    = 1'b0;
        queued_handles.delete();
    endtask

    // mostly well-formed traffic: add, acquire, release the held handle, remove;
    // the rest is noise with null, stale or random handles and any operation
    task automatic random_request();
        func_t            op;
        logic [MSG_W-1:0] handle;
        int unsigned      occupied;
        int unsigned      roll;
        bit               can_add;
        bit               can_take;
        bit               can_drop;
        occupied = queued_cnt + stale_cnt;
        handle   = fresh_handle();
        roll     = $urandom_range(0, 99);
        if (roll < 15)
        begin
            op = func_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: handle = '0;
                1: if (queued_handles.size() != 0) handle = queued_handles[0];
                default: ;
            endcase
        end
        else if (holding)
        begin
            // now and then a second acquire while holding
            op = ($urandom_range(0, 9) == 0) ? FUNC_ACQUIRE : FUNC_RELEASE;
            handle = queued_handles[0];
        end
        else
        begin
            // keep one slot spare most of the time; a full ring can lock up until resized
            can_add  = (occupied + 1 < ring_n) ||
                       (occupied < ring_n && $urandom_range(0, 19) == 0);
            can_take = queued_cnt != 0 && queued_cnt != ring_n;
            can_drop = stale_cnt != 0 && stale_cnt != ring_n;
            roll = $urandom_range(0, 99);
            if (can_add && (roll < 40 || (!can_take && !can_drop)))
                op = FUNC_ADD;
            else if (can_take && (roll < 70 || !can_drop))
                op = FUNC_ACQUIRE;
            else if (can_drop)
                op = FUNC_REMOVE;
            else
                op = func_t'($urandom_range(0, 3));
        end
        send_request(op, handle);
    endtask

    // reply side: stalls at random, with stall-free stretches, plus one long hold-off
    // while requests keep coming so the block backs up and stops taking input
    initial
    begin
        int unsigned lag;
        int unsigned stall_pct;
        int unsigned chunk;
        rsp_ch.ready <= 1'b0;
        stall_pct = 0;
        chunk = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (chunk == 0)
            begin
                chunk = 64;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            chunk--;
            // well inside the long phase at full ring size, so requests keep coming
            if (!backlog_done && requests_sent >= 550)
            begin
                backlog_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                lag = 400;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                lag = pick_gap();
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                lag = $urandom_range(1, 6);
            end
            repeat (lag) @(posedge clk);
        end
    end

    // request side: reset, directed cases, random phases per size, verdict
    initial
    begin
        int unsigned phase_items;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_ADD;
        req_ch.msg   <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        rst_n = 1'b0;
        requests_sent = 0;
        backlog_done  = 1'b0;
        send_idle_pct = 30;
        ring_n = SIZE_RESET;
        queued_cnt = 0;
        stale_cnt  = 0;
        holding    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset size: empty ring, null handles, handle extremes,
        // acquire and release out of order, unmatched release, full round trip
        send_request(FUNC_ACQUIRE, 32'h0000_0000);
        send_request(FUNC_REMOVE,  32'hFFFF_FFFF);
        send_request(FUNC_RELEASE, 32'h0000_0000);
        send_request(FUNC_ADD,     32'h0000_0000);
        send_request(FUNC_ADD,     32'hFFFF_FFFF);
        send_request(FUNC_ADD,     32'h0000_0001);
        send_request(FUNC_RELEASE, 32'hFFFF_FFFF);
        send_request(FUNC_ACQUIRE, 32'h0000_0000);
        send_request(FUNC_ACQUIRE, 32'h0000_0000);
        send_request(FUNC_RELEASE, 32'h0000_0001);
        send_request(FUNC_RELEASE, 32'hFFFF_FFFF);
        send_request(FUNC_REMOVE,  32'h0000_0000);
        send_request(FUNC_REMOVE,  32'h0000_0000);
        send_request(FUNC_ACQUIRE, 32'h0000_0000);
        send_request(FUNC_RELEASE, 32'h0000_0001);
        send_request(FUNC_REMOVE,  32'h0000_0000);

        // two-slot ring filled: add reports full, acquire sees read on write,
        // remove sees free on read
        write_ring_size(7'd2);
        send_request(FUNC_ADD,     32'hA5A5_A5A5);
        send_request(FUNC_ADD,     32'h5A5A_5A5A);
        send_request(FUNC_ADD,     32'h0000_0003);
        send_request(FUNC_ACQUIRE, 32'h0000_0000);
        send_request(FUNC_REMOVE,  32'h0000_0000);

        // random phases, one per size setting; pacing varies from phase to phase
        for (int p = 0; p < 13; p++)
        begin
            write_ring_size(size_plan[p]);
            send_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 70;
            phase_items = (ring_n >= 32) ? 250 : 60;
            for (int unsigned i = 0; i < phase_items; i++)
            begin
                // one mid-phase pause until the block has answered everything
                if (p == 3 && i == phase_items / 2)
                    wait_all_results();
                random_request();
            end
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[reclaiming_ring_message_queue_top] OK");
        else
            $display("[reclaiming_ring_message_queue_top] ERROR");
        $finish;
    end

endmodule
